@@ rtl/tspf_pkg.sv @@
// ----------------------------------------------------------------------------
// tspf_pkg
// Shared constants for the touch sample pressure filter.
// ----------------------------------------------------------------------------
package tspf_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned PlateW    = 16;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned PressW    = 20;
  localparam int unsigned SumW      = 15;
  localparam int unsigned MinW      = 13;
  localparam int unsigned CountW    = 3;
  localparam int unsigned ShiftCntW = 5;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 1;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [SampleW-1:0]   Z1Floor      = 12'd10;
  localparam logic [SampleW-1:0]   Z2Ceil       = 12'd4086;
  localparam logic [ProdW:0]       RoundAdd     = 33'd2047;
  localparam int unsigned          PressShift   = 12;
  localparam logic [CountW-1:0]    BurstLen     = 3'd6;
  localparam logic [MinW-1:0]      SmallestInit = 13'd4096;
  localparam logic [PlateW-1:0]    PlateReset   = 16'd660;

  // register index 0 decodes from address bit 2
  localparam logic [ApbAddrW-1:0]  RegPlateAddr = 3'd0;

  localparam logic [ShiftCntW-1:0] MulXSteps = ShiftCntW'(SampleW - 1);
  localparam logic [ShiftCntW-1:0] MulPSteps = ShiftCntW'(PlateW - 1);
  localparam logic [ShiftCntW-1:0] DivSteps  = ShiftCntW'(ProdW - 1);

endpackage

@@ rtl/touch_sample_pressure_filter.sv @@
// ----------------------------------------------------------------------------
// touch_sample_pressure_filter
// Pressure check and six-sample trimmed mean for resistive touch samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A sample that passes the pen, read and
// Z1/Z2 checks runs through a bit-serial shift-add multiplier (12 steps for
// X, 16 steps for the plate resistance) and a restoring divider by Z1 that
// retires one quotient bit per cycle (32 steps); a sample rejected by the
// checks goes straight to the done state. No new sample is taken until the
// current one is finished. The six-sample burst bookkeeping and the result
// load happen in the done state, which waits while the output register
// still holds an untaken result. A bad sample gives an abort result; the
// sixth good sample since the last result gives the trimmed mean of X and Y.
module touch_sample_pressure_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // raw_x [11:0], raw_y [23:12], raw_z1 [35:24], raw_z2 [47:36]
  input  logic [tspf_pkg::InDataW-1:0]   s_axis_tdata,
  // pen_down [0], read_failed [1]
  input  logic [tspf_pkg::InUserW-1:0]   s_axis_tuser,
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // avg_x [11:0], avg_y [23:12], last_pressure [43:24], zero [47:44]
  output logic [tspf_pkg::OutDataW-1:0]  m_axis_tdata,
  // ok [0]
  output logic [tspf_pkg::OutUserW-1:0]  m_axis_tuser,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tspf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tspf_pkg::ApbDataW-1:0]  pwdata,
  output logic [tspf_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULP,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  logic [tspf_pkg::PlateW-1:0]    plate_q;
  logic [tspf_pkg::SampleW-1:0]   x_q, x_d, y_q, y_d, z1_q, z1_d;
  logic [tspf_pkg::PlateW-1:0]    mplier_q, mplier_d;
  logic [tspf_pkg::ProdW-1:0]     mcand_q, mcand_d, acc_q, acc_d;
  logic [tspf_pkg::SampleW-1:0]   rem_q, rem_d;
  logic [tspf_pkg::ShiftCntW-1:0] cnt_q, cnt_d;

  logic [tspf_pkg::CountW-1:0]    good_q, good_d;
  logic [tspf_pkg::SumW-1:0]      sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [tspf_pkg::SampleW-1:0]   max_x_q, max_x_d, max_y_q, max_y_d;
  logic [tspf_pkg::MinW-1:0]      min_x_q, min_x_d, min_y_q, min_y_d;

  logic                           m_valid_q, m_valid_d;
  logic [tspf_pkg::OutDataW-1:0]  m_data_q, m_data_d;
  logic [tspf_pkg::OutUserW-1:0]  m_user_q, m_user_d;

  logic                           s_xfer, cfg_wr;
  logic [tspf_pkg::SampleW-1:0]   in_x, in_y, in_z1, in_z2;
  logic                           in_pen, in_fail, in_good;
  logic [tspf_pkg::ProdW-1:0]     add_w, diff_w;
  logic [tspf_pkg::SampleW:0]     trial_w, trial_sub;
  logic                           trial_ge;
  logic [tspf_pkg::ProdW:0]       round_w;
  logic [tspf_pkg::PressW-1:0]    press_w;
  logic                           slot_free;
  logic [tspf_pkg::SumW-1:0]      nsum_x, nsum_y;
  logic [tspf_pkg::SampleW-1:0]   nmax_x, nmax_y;
  logic [tspf_pkg::MinW-1:0]      nmin_x, nmin_y;
  logic [tspf_pkg::CountW-1:0]    ngood;
  logic [tspf_pkg::SumW:0]        trim_x, trim_y;

  assign in_x    = s_axis_tdata[11:0];
  assign in_y    = s_axis_tdata[23:12];
  assign in_z1   = s_axis_tdata[35:24];
  assign in_z2   = s_axis_tdata[47:36];
  assign in_pen  = s_axis_tuser[0];
  assign in_fail = s_axis_tuser[1];
  assign in_good = in_pen && !in_fail && (in_z1 > tspf_pkg::Z1Floor)
                   && (in_z2 < tspf_pkg::Z2Ceil);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = (paddr[2] == tspf_pkg::RegPlateAddr[2])
                  ? tspf_pkg::ApbDataW'(plate_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plate_q <= tspf_pkg::PlateReset;
    end else if (cfg_wr) begin
      plate_q <= pwdata[tspf_pkg::PlateW-1:0];
    end
  end

  // shared datapath pieces
  assign diff_w    = tspf_pkg::ProdW'(in_z2) - tspf_pkg::ProdW'(in_z1);
  assign add_w     = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign trial_w   = {rem_q, acc_q[tspf_pkg::ProdW-1]};
  assign trial_ge  = (trial_w >= {1'b0, z1_q});
  assign trial_sub = trial_w - {1'b0, z1_q};
  assign round_w   = {1'b0, acc_q} + tspf_pkg::RoundAdd;
  assign press_w   = round_w[tspf_pkg::PressShift +: tspf_pkg::PressW];
  assign slot_free = !m_valid_q || m_axis_tready;

  // burst bookkeeping with the current sample folded in
  assign nsum_x = sum_x_q + tspf_pkg::SumW'(x_q);
  assign nsum_y = sum_y_q + tspf_pkg::SumW'(y_q);
  assign nmax_x = (x_q > max_x_q) ? x_q : max_x_q;
  assign nmax_y = (y_q > max_y_q) ? y_q : max_y_q;
  assign nmin_x = (tspf_pkg::MinW'(x_q) < min_x_q) ? tspf_pkg::MinW'(x_q) : min_x_q;
  assign nmin_y = (tspf_pkg::MinW'(y_q) < min_y_q) ? tspf_pkg::MinW'(y_q) : min_y_q;
  assign ngood  = good_q + 1'b1;
  assign trim_x = (tspf_pkg::SumW+1)'(nsum_x) - (tspf_pkg::SumW+1)'(nmax_x)
                  - (tspf_pkg::SumW+1)'(nmin_x);
  assign trim_y = (tspf_pkg::SumW+1)'(nsum_y) - (tspf_pkg::SumW+1)'(nmax_y)
                  - (tspf_pkg::SumW+1)'(nmin_y);

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    z1_d      = z1_q;
    mplier_d  = mplier_q;
    mcand_d   = mcand_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    good_d    = good_q;
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    max_x_d   = max_x_q;
    max_y_d   = max_y_q;
    min_x_d   = min_x_q;
    min_y_d   = min_y_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          x_d      = in_x;
          y_d      = in_y;
          z1_d     = in_z1;
          mplier_d = tspf_pkg::PlateW'(in_x);
          mcand_d  = diff_w;
          acc_d    = '0;
          cnt_d    = tspf_pkg::MulXSteps;
          // a rejected sample skips the arithmetic with zero pressure
          state_d  = in_good ? ST_MULX : ST_DONE;
        end
      end
      ST_MULX: begin
        acc_d    = add_w;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          mcand_d  = add_w;
          acc_d    = '0;
          mplier_d = plate_q;
          cnt_d    = tspf_pkg::MulPSteps;
          state_d  = ST_MULP;
        end
      end
      ST_MULP: begin
        acc_d    = add_w;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = tspf_pkg::DivSteps;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // dividend shifts out the top while quotient bits enter the bottom
        rem_d = trial_ge ? trial_sub[tspf_pkg::SampleW-1:0]
                         : trial_w[tspf_pkg::SampleW-1:0];
        acc_d = {acc_q[tspf_pkg::ProdW-2:0], trial_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
          if (press_w == '0 || ngood == tspf_pkg::BurstLen) begin
            m_valid_d = 1'b1;
            if (press_w == '0) begin
              m_user_d = '0;
              m_data_d = '0;
            end else begin
              m_user_d = 1'b1;
              m_data_d = {4'd0, press_w, trim_y[13:2], trim_x[13:2]};
            end
            good_d  = '0;
            sum_x_d = '0;
            sum_y_d = '0;
            max_x_d = '0;
            max_y_d = '0;
            min_x_d = tspf_pkg::SmallestInit;
            min_y_d = tspf_pkg::SmallestInit;
          end else begin
            good_d  = ngood;
            sum_x_d = nsum_x;
            sum_y_d = nsum_y;
            max_x_d = nmax_x;
            max_y_d = nmax_y;
            min_x_d = nmin_x;
            min_y_d = nmin_y;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      good_q    <= '0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      max_x_q   <= '0;
      max_y_q   <= '0;
      min_x_q   <= tspf_pkg::SmallestInit;
      min_y_q   <= tspf_pkg::SmallestInit;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      good_q    <= good_d;
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
      max_x_q   <= max_x_d;
      max_y_q   <= max_y_d;
      min_x_q   <= min_x_d;
      min_y_q   <= min_y_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    z1_q     <= z1_d;
    mplier_q <= mplier_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

@@ rtl/tspf_checker.sv @@
// ----------------------------------------------------------------------------
// tspf_checker
// Port-level checks for the touch sample pressure filter.
// ----------------------------------------------------------------------------
module tspf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tspf_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [tspf_pkg::OutUserW-1:0]  m_axis_tuser
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an aborted burst carries all-zero data
  a_abort_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("abort result with nonzero data");

  // a valid average always comes from a sample with pressure
  a_ok_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[43:24] != '0)
    else $error("valid result with zero pressure");

  // in the cycle after a transfer the block is not ready
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready returned too early");

endmodule

bind touch_sample_pressure_filter tspf_checker u_tspf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
